// ===== hdl/two_channel_block_averager_assert.svh =====
// Assertion macros for the two-channel block averager.
`ifndef TWO_CHANNEL_BLOCK_AVERAGER_ASSERT_SVH
`define TWO_CHANNEL_BLOCK_AVERAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/tcba_pkg.sv =====
// Shared constants and types for the two-channel block averager.
package tcba_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_WINDOW_DEF  = 2000;
    localparam int FRAC_BITS_DEF   = 6;

    localparam int RES_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MODE_W     = 2;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_CH0        = 2'd0;
    localparam t_mode MODE_CH1        = 2'd1;
    localparam t_mode MODE_SWITCH_WIN = 2'd2;
    localparam t_mode MODE_SWITCH_SMP = 2'd3;

    localparam t_cfg_idx REG_MODE = 2'd0;
    localparam t_cfg_idx REG_WIN0 = 2'd1;
    localparam t_cfg_idx REG_WIN1 = 2'd2;

endpackage

// ===== hdl/two_channel_block_averager.sv =====
// Two-channel block averager with a shared restoring divider for the window average.
//
// channel  direction  handshake           payload
// in       sink       i_in_valid/o_in_stall   i_sample
// out      source     o_out_valid/i_out_stall o_channel, o_sum, o_count, o_average,
//                                             o_result_number
// cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A non-closing item adds to its sum; the next may follow at once unless i_cfg_valid.
// A window-closing item loads the divider, which forms one average bit per cycle;
// the load state then moves the result to the result register. Input stalls meanwhile.
// The result register lets a new item enter while a result waits on o_out_valid;
// a second window result waits in the load state until that register drains.
// Reset is synchronous and active low; a configuration write clears all sums and counts.
module two_channel_block_averager #(
    parameter int  SAMPLE_BITS = tcba_pkg::SAMPLE_BITS_DEF,
    parameter int  MAX_WINDOW  = tcba_pkg::MAX_WINDOW_DEF,
    parameter int  FRAC_BITS   = tcba_pkg::FRAC_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W       = SAMPLE_BITS + CNT_W,
    localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_channel,
    output logic [SUM_W-1:0]                o_sum,
    output logic [CNT_W-1:0]                o_count,
    output logic [AVG_W-1:0]                o_average,
    output logic [tcba_pkg::RES_W-1:0]      o_result_number,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    `include "two_channel_block_averager_assert.svh"

    localparam int DVD_W  = SUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(AVG_W + 1);
    localparam int RES_W  = tcba_pkg::RES_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          r_state, n_state;
    tcba_pkg::t_mode     r_mode, n_mode;
    logic [CNT_W-1:0]    r_win0, n_win0, r_win1, n_win1;
    logic                r_chan, n_chan;
    logic [SUM_W-1:0]    r_sum0, n_sum0, r_sum1, n_sum1;
    logic [CNT_W-1:0]    r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic [RES_W-1:0]    r_res0, n_res0, r_res1, n_res1;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    logic                r_div_chan;
    logic [SUM_W-1:0]    r_div_sum;
    logic [CNT_W-1:0]    r_div_cnt;
    logic [RES_W-1:0]    r_div_res;
    logic [CNT_W-1:0]    r_rem;
    logic [AVG_W-1:0]    r_quo;

    logic                r_out_chan;
    logic [SUM_W-1:0]    r_out_sum;
    logic [CNT_W-1:0]    r_out_cnt;
    logic [AVG_W-1:0]    r_out_avg;
    logic [RES_W-1:0]    r_out_res;

    logic                w_acc;
    logic                w_cfg;
    logic                w_load;
    logic [SUM_W-1:0]    w_cur_sum, w_new_sum;
    logic [CNT_W-1:0]    w_cur_cnt, w_new_cnt, w_cur_win;
    logic [RES_W-1:0]    w_cur_res, w_new_res;
    logic                w_done;
    logic [DVD_W-1:0]    w_dvd;
    logic [CNT_W:0]      w_trial, w_diff;
    logic                w_ge;
    logic [CNT_W-1:0]    w_rem_next;
    logic [31:0]         w_cfg_val;
    logic [CNT_W-1:0]    w_win_clamp;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) | i_cfg_valid;
    assign w_acc       = i_in_valid & ~o_in_stall;
    assign w_cfg       = i_cfg_valid & o_cfg_ready;
    assign w_load      = (r_state == S_OUT) & ~(r_out_valid & i_out_stall);

    assign w_cur_sum = r_chan ? r_sum1 : r_sum0;
    assign w_cur_cnt = r_chan ? r_cnt1 : r_cnt0;
    assign w_cur_win = r_chan ? r_win1 : r_win0;
    assign w_cur_res = r_chan ? r_res1 : r_res0;
    assign w_new_sum = w_cur_sum + SUM_W'(i_sample);
    assign w_new_cnt = w_cur_cnt + CNT_W'(1);
    assign w_new_res = w_cur_res + RES_W'(1);
    assign w_done    = (w_new_cnt >= w_cur_win);
    assign w_dvd     = DVD_W'(w_new_sum) << FRAC_BITS;

    assign w_trial    = {r_rem, r_quo[AVG_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_div_cnt});
    assign w_diff     = w_trial - {1'b0, r_div_cnt};
    assign w_rem_next = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];

    assign w_cfg_val   = 32'(i_cfg_data);
    assign w_win_clamp = (w_cfg_val == 32'd0) ? CNT_W'(1) :
                         (w_cfg_val > 32'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) :
                         CNT_W'(w_cfg_val);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_win0      = r_win0;
        n_win1      = r_win1;
        n_chan      = r_chan;
        n_sum0      = r_sum0;
        n_sum1      = r_sum1;
        n_cnt0      = r_cnt0;
        n_cnt1      = r_cnt1;
        n_res0      = r_res0;
        n_res1      = r_res1;
        n_step      = r_step;
        n_out_valid = r_out_valid & i_out_stall;

        if (w_cfg) begin
            unique case (i_cfg_index)
                tcba_pkg::REG_MODE: n_mode = i_cfg_data[tcba_pkg::MODE_W-1:0];
                tcba_pkg::REG_WIN0: n_win0 = w_win_clamp;
                tcba_pkg::REG_WIN1: n_win1 = w_win_clamp;
                default: ;
            endcase
            n_chan = (n_mode == tcba_pkg::MODE_CH1);
            n_sum0 = '0;
            n_sum1 = '0;
            n_cnt0 = '0;
            n_cnt1 = '0;
            n_res0 = '0;
            n_res1 = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_done) begin
                        n_state = S_DIV;
                        n_step  = '0;
                        if (r_chan) begin
                            n_sum1 = '0;
                            n_cnt1 = '0;
                            n_res1 = w_new_res;
                        end else begin
                            n_sum0 = '0;
                            n_cnt0 = '0;
                            n_res0 = w_new_res;
                        end
                        if (r_mode == tcba_pkg::MODE_SWITCH_WIN) begin
                            n_chan = ~r_chan;
                        end
                    end else begin
                        if (r_chan) begin
                            n_sum1 = w_new_sum;
                            n_cnt1 = w_new_cnt;
                        end else begin
                            n_sum0 = w_new_sum;
                            n_cnt0 = w_new_cnt;
                        end
                    end
                    if (r_mode == tcba_pkg::MODE_SWITCH_SMP) begin
                        n_chan = ~r_chan;
                    end
                end
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(AVG_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= tcba_pkg::MODE_SWITCH_WIN;
            r_win0      <= CNT_W'(1);
            r_win1      <= CNT_W'(1);
            r_chan      <= 1'b0;
            r_sum0      <= '0;
            r_sum1      <= '0;
            r_cnt0      <= '0;
            r_cnt1      <= '0;
            r_res0      <= '0;
            r_res1      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_win0      <= n_win0;
            r_win1      <= n_win1;
            r_chan      <= n_chan;
            r_sum0      <= n_sum0;
            r_sum1      <= n_sum1;
            r_cnt0      <= n_cnt0;
            r_cnt1      <= n_cnt1;
            r_res0      <= n_res0;
            r_res1      <= n_res1;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_acc && w_done) begin
            r_div_chan <= r_chan;
            r_div_sum  <= w_new_sum;
            r_div_cnt  <= w_new_cnt;
            r_div_res  <= w_new_res;
            r_rem      <= w_dvd[DVD_W-1:AVG_W];
            r_quo      <= w_dvd[AVG_W-1:0];
        end else if (r_state == S_DIV) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[AVG_W-2:0], w_ge};
        end
        if (w_load) begin
            r_out_chan <= r_div_chan;
            r_out_sum  <= r_div_sum;
            r_out_cnt  <= r_div_cnt;
            r_out_avg  <= r_quo;
            r_out_res  <= r_div_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel       = r_out_chan;
    assign o_sum           = r_out_sum;
    assign o_count         = r_out_cnt;
    assign o_average       = r_out_avg;
    assign o_result_number = r_out_res;

    `TCBA_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div_cnt != '0, "divisor is zero")
    `TCBA_ASSERT_IMPL(a_cnt_below_win, i_clk, i_rst_n, r_state == S_IDLE, (r_cnt0 < r_win0) && (r_cnt1 < r_win1), "count reached window while idle")
    `TCBA_ASSERT_NEXT(a_win_clears, i_clk, i_rst_n, (r_state == S_IDLE) && w_acc && w_done, (r_state == S_DIV) && (((r_div_chan == 1'b1) && (r_cnt1 == '0)) || ((r_div_chan == 1'b0) && (r_cnt0 == '0))), "closed window not cleared")
    `TCBA_ASSERT_IMPL(a_out_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_OUT, "result shown without divider load")

endmodule
